// ===== sv/brbf_pkg.sv =====
// ----------------------------------------------------------------------------
// brbf_pkg
// shared types and constants of the circular byte fifo
// ----------------------------------------------------------------------------
package brbf_pkg;

  // storage geometry
  localparam int DEPTH     = 1024;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CAP_W     = IDX_W + 1;
  localparam int CAP_MIN   = 2;
  localparam int CAP_RESET = 1024;

  // longest read or peek burst
  localparam int MAX_BURST = 16;
  localparam int BURST_W   = $clog2(MAX_BURST + 1);

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  // action codes on the input beat
  localparam logic [2:0] ACT_WRITE = 3'd0;
  localparam logic [2:0] ACT_READ  = 3'd1;
  localparam logic [2:0] ACT_PEEK  = 3'd2;
  localparam logic [2:0] ACT_SKIP  = 3'd3;
  localparam logic [2:0] ACT_FLUSH = 3'd4;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_PEEK,
    CMD_SKIP,
    CMD_FLUSH,
    CMD_NOP
  } cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } back_state_e;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_in;
    logic [9:0] count;
  } item_in_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       ok;
    logic       last;
    logic [9:0] moved;
    logic [9:0] fill_level;
    logic [9:0] free_space;
  } item_out_t;

  // classified command held in the queue
  typedef struct packed {
    cmd_e       op;
    logic [7:0] data_in;
    logic [9:0] count;
  } cmd_t;

  // queue handshake toward the back part
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

  // beat metadata in the read stage of the back part
  typedef struct packed {
    logic             use_mem;
    logic             ok;
    logic             last;
    logic [IDX_W-1:0] moved;
    logic [IDX_W-1:0] fill;
  } beat_t;

endpackage

// ===== sv/brbf_front.sv =====
// ----------------------------------------------------------------------------
// brbf_front
// accepts input beats, decodes the action and queues the command
// ----------------------------------------------------------------------------
module brbf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  brbf_pkg::item_in_t   in_data_i,
  output brbf_pkg::queue_head_t head_o,
  input  logic                 pop_i
);
  import brbf_pkg::*;

  cmd_t            slot_q [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QP_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QC_W-1:0] cnt_q, cnt_d;
  logic            push;
  cmd_t            cmd_in;

  assign in_stall_o = (cnt_q == QC_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;

  // decode
  always_comb begin
    cmd_in.data_in = in_data_i.data_in;
    cmd_in.count   = in_data_i.count;
    unique case (in_data_i.action)
      ACT_WRITE: cmd_in.op = CMD_WRITE;
      ACT_READ:  cmd_in.op = CMD_READ;
      ACT_PEEK:  cmd_in.op = CMD_PEEK;
      ACT_SKIP:  cmd_in.op = CMD_SKIP;
      ACT_FLUSH: cmd_in.op = CMD_FLUSH;
      default:   cmd_in.op = CMD_NOP;
    endcase
  end

  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + QP_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + QP_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + QC_W'(1);
    end else if (pop_i && !push) begin
      cnt_d = cnt_q - QC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = slot_q[rd_ptr_q];

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop from empty command queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QC_W'(QUEUE_DEPTH))
    else $error("command queue count out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with unequal pointers");

endmodule

// ===== sv/brbf_back.sv =====
// ----------------------------------------------------------------------------
// brbf_back
// executes queued commands against the byte store and emits result beats
// ----------------------------------------------------------------------------
module brbf_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [10:0]           cfg_wdata_i,
  input  brbf_pkg::queue_head_t head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output brbf_pkg::item_out_t   out_data_o
);
  import brbf_pkg::*;

  back_state_e state_q, state_d;

  logic [CAP_W-1:0]   cap_q;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]   wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0]   fill_q, fill_d;
  logic [IDX_W-1:0]   b_idx_q, b_idx_d;
  logic [BURST_W-1:0] b_cnt_q, b_cnt_d;
  logic [IDX_W-1:0]   b_moved_q, b_moved_d;

  logic [7:0] storage_q [DEPTH];
  logic [7:0] mem_rdata_q;
  logic       mem_we, mem_re;
  logic [IDX_W-1:0] rd_addr;

  logic      s1_v_q;
  beat_t     s1_q, beat;
  logic      issue;
  logic      out_v_q;
  item_out_t out_q;
  logic      out_free, s1_ready;

  logic [CAP_W-1:0]   cap_in;
  logic               full;
  logic [IDX_W-1:0]   n_lim, adv_n;
  logic [BURST_W-1:0] n_burst;
  logic [CAP_W-1:0]   adv_sum, adv_wrap, free_w;
  logic               is_burst_cmd;

  function automatic logic [IDX_W-1:0] inc_wrap(logic [IDX_W-1:0] idx,
                                                logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] nxt;
    nxt = CAP_W'(idx) + CAP_W'(1);
    return (nxt == cap) ? '0 : nxt[IDX_W-1:0];
  endfunction

  assign out_free = !out_v_q || !out_stall_i;
  assign s1_ready = !s1_v_q || out_free;

  // capacity clamp at write time
  always_comb begin
    if (cfg_wdata_i < CAP_W'(CAP_MIN)) begin
      cap_in = CAP_W'(CAP_MIN);
    end else if (cfg_wdata_i > CAP_W'(DEPTH)) begin
      cap_in = CAP_W'(DEPTH);
    end else begin
      cap_in = cfg_wdata_i;
    end
  end

  // command classification against current occupancy
  always_comb begin
    full    = (CAP_W'(fill_q) == cap_q - CAP_W'(1));
    n_lim   = (head_i.cmd.count < fill_q) ? head_i.cmd.count : fill_q;
    n_burst = (n_lim > IDX_W'(MAX_BURST)) ? BURST_W'(MAX_BURST) : n_lim[BURST_W-1:0];
    adv_n   = (head_i.cmd.op == CMD_READ) ? IDX_W'(n_burst) : n_lim;
    adv_sum = CAP_W'(rd_idx_q) + CAP_W'(adv_n);
    adv_wrap = (adv_sum >= cap_q) ? adv_sum - cap_q : adv_sum;
    is_burst_cmd = (head_i.cmd.op == CMD_READ || head_i.cmd.op == CMD_PEEK);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid && s1_ready && is_burst_cmd && n_burst > BURST_W'(1)) begin
          state_d = ST_BURST;
        end
      end
      ST_BURST: begin
        if (s1_ready && b_cnt_q == BURST_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop_o     = 1'b0;
    issue     = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    rd_addr   = rd_idx_q;
    rd_idx_d  = rd_idx_q;
    wr_idx_d  = wr_idx_q;
    fill_d    = fill_q;
    b_idx_d   = b_idx_q;
    b_cnt_d   = b_cnt_q;
    b_moved_d = b_moved_q;
    beat      = '{use_mem: 1'b0, ok: 1'b0, last: 1'b1, moved: '0, fill: fill_q};
    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid && s1_ready) begin
          pop_o = 1'b1;
          issue = 1'b1;
          unique case (head_i.cmd.op)
            CMD_WRITE: begin
              if (!full) begin
                mem_we     = 1'b1;
                wr_idx_d   = inc_wrap(wr_idx_q, cap_q);
                fill_d     = fill_q + IDX_W'(1);
                beat.ok    = 1'b1;
                beat.moved = IDX_W'(1);
              end
            end
            CMD_READ, CMD_PEEK: begin
              if (n_burst != '0) begin
                mem_re       = 1'b1;
                beat.use_mem = 1'b1;
                beat.ok      = 1'b1;
                beat.last    = (n_burst == BURST_W'(1));
                beat.moved   = IDX_W'(n_burst);
                b_idx_d      = inc_wrap(rd_idx_q, cap_q);
                b_cnt_d      = n_burst - BURST_W'(1);
                b_moved_d    = IDX_W'(n_burst);
                if (head_i.cmd.op == CMD_READ) begin
                  rd_idx_d = adv_wrap[IDX_W-1:0];
                  fill_d   = fill_q - IDX_W'(n_burst);
                end
              end
            end
            CMD_SKIP: begin
              rd_idx_d   = adv_wrap[IDX_W-1:0];
              fill_d     = fill_q - n_lim;
              beat.ok    = (n_lim != '0);
              beat.moved = n_lim;
            end
            CMD_FLUSH: begin
              rd_idx_d   = wr_idx_q;
              fill_d     = '0;
              beat.ok    = 1'b1;
              beat.moved = fill_q;
            end
            default: ;
          endcase
          beat.fill = fill_d;
        end
      end
      ST_BURST: begin
        if (s1_ready) begin
          issue        = 1'b1;
          mem_re       = 1'b1;
          rd_addr      = b_idx_q;
          beat.use_mem = 1'b1;
          beat.ok      = 1'b1;
          beat.last    = (b_cnt_q == BURST_W'(1));
          beat.moved   = b_moved_q;
          b_idx_d      = inc_wrap(b_idx_q, cap_q);
          b_cnt_d      = b_cnt_q - BURST_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cap_q    <= CAP_W'(CAP_RESET);
      rd_idx_q <= '0;
      wr_idx_q <= '0;
      fill_q   <= '0;
      b_cnt_q  <= '0;
      s1_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      b_cnt_q <= b_cnt_d;
      if (cfg_we_i) begin
        cap_q    <= cap_in;
        rd_idx_q <= '0;
        wr_idx_q <= '0;
        fill_q   <= '0;
      end else begin
        rd_idx_q <= rd_idx_d;
        wr_idx_q <= wr_idx_d;
        fill_q   <= fill_d;
      end
      if (s1_ready) begin
        s1_v_q <= issue;
      end
      if (out_free) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    b_idx_q   <= b_idx_d;
    b_moved_q <= b_moved_d;
    if (issue) begin
      s1_q <= beat;
    end
    if (out_free && s1_v_q) begin
      out_q.data_out   <= s1_q.use_mem ? mem_rdata_q : 8'd0;
      out_q.ok         <= s1_q.ok;
      out_q.last       <= s1_q.last;
      out_q.moved      <= s1_q.moved;
      out_q.fill_level <= s1_q.fill;
      out_q.free_space <= free_w[IDX_W-1:0];
    end
  end

  assign free_w = cap_q - CAP_W'(s1_q.fill) - CAP_W'(1);

  // byte store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      storage_q[wr_idx_q] <= head_i.cmd.data_in;
    end
    if (mem_re) begin
      mem_rdata_q <= storage_q[rd_addr];
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CAP_W'(fill_q) < cap_q)
    else $error("fill level reached capacity");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CAP_W'(rd_idx_q) < cap_q && CAP_W'(wr_idx_q) < cap_q)
    else $error("index outside active region");

  a_burst_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BURST |-> b_cnt_q != '0)
    else $error("burst state with no beats left");

  a_mem_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("store read and written in one cycle");

endmodule

// ===== sv/byte_ring_buffer_fifo_unit.sv =====
// ----------------------------------------------------------------------------
// byte_ring_buffer_fifo_unit
// circular byte fifo, one slot kept empty, with burst read, peek, skip, flush
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       input      in_valid_i / in_stall_o   brbf_pkg::item_in_t
//  out      output     out_valid_o / out_stall_i brbf_pkg::item_out_t
//  cfg      input      cfg_we_i                  capacity, 11 bits
//
//  write, skip, flush and refused actions: one beat, one command per cycle while the output is not stalled
//  read and peek bursts: n beats, n = min(count, fill, 16), one store read per
//    beat through the single read port of the byte store; n = 0 gives one refused beat
//  reset: empty fifo, capacity 1024; store contents undefined until written
//  a stalled output stops the back part once its read stage holds a beat; the
//    2-entry command queue keeps the input open until it fills
// ----------------------------------------------------------------------------
module byte_ring_buffer_fifo_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration, capacity register
  input  logic                cfg_we_i,
  input  logic [10:0]         cfg_wdata_i,
  // input beats
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  brbf_pkg::item_in_t  in_data_i,
  // result beats
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output brbf_pkg::item_out_t out_data_o
);
  import brbf_pkg::*;

  // head of the command queue and its pop strobe
  queue_head_t head;
  logic        pop;

  // front: takes input beats, decodes the action, queues the command
  brbf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  // back: owns the indices and the store, sequences bursts, drives result beats
  brbf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
